### rtl/rlbs_pkg.sv
// ----------------------------------------------------------------------------
// rlbs_pkg
// Shared types and codes for the run-length bitmap store.
// ----------------------------------------------------------------------------
package rlbs_pkg;

  localparam int MAX_RUNS_DEF = 256;
  localparam int RUN_BITS_DEF = 16;

  // Linear bit index y*width+x always fits 16 bits for 8-bit coordinates.
  localparam int POS_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [7:0] GRID_WIDTH_RST  = 8'd10;
  localparam logic [7:0] GRID_HEIGHT_RST = 8'd10;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OOB  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic       set_value;
  } cmd_t;

  typedef struct packed {
    logic       bit_value;
    logic [1:0] status;
    logic       is_empty;
    logic [8:0] runs_used;
  } res_t;

endpackage

### rtl/run_length_bitmap_store_core.sv
// ----------------------------------------------------------------------------
// run_length_bitmap_store_core
// Bitmap kept as alternating run lengths; read, write and clear one bit.
// ----------------------------------------------------------------------------
// Channel   Signals                          Direction  Handshake
// command   start, busy, cmd                 in         start && !busy
// result    done, result                     out        done, one cycle
// config    cfg_we, cfg_idx, cfg_data        in         cfg_we, no wait
//
// A read walks the run store at one run per cycle through the single memory
// read port. A write adds the neighbor read, a move of up to MAX_RUNS-1
// entries (one per cycle, read and write port overlapped) and up to three
// patch writes. Reset is synchronous; entry 0 of the store is tracked by a
// flag and reads as the bitmap size after reset, clear or a register write,
// so no clearing pass is needed. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module run_length_bitmap_store_core #(
  parameter int MAX_RUNS = rlbs_pkg::MAX_RUNS_DEF,
  parameter int RUN_BITS = rlbs_pkg::RUN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  rlbs_pkg::cmd_t                 cmd,
  output logic                           done,
  output rlbs_pkg::res_t                 result,
  input  logic                           cfg_we,
  input  logic [rlbs_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]                     cfg_data
);
  import rlbs_pkg::*;

  localparam int AW = $clog2(MAX_RUNS);
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int VW = ((RUN_BITS > POS_W) ? RUN_BITS : POS_W) + 1;
  localparam logic [VW-1:0] RUN_MAX = {{(VW-RUN_BITS){1'b0}}, {RUN_BITS{1'b1}}};
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RUNS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHK   = 8'b0000_0010,
    S_WALK  = 8'b0000_0100,
    S_NRD   = 8'b0000_1000,
    S_NCAP  = 8'b0001_0000,
    S_MOVE  = 8'b0010_0000,
    S_PATCH = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration and bitmap state
  logic [7:0]    grid_width, grid_height;
  logic [CW-1:0] run_count;
  logic          first_zero;
  logic          head_fresh;   // entry 0 holds the bitmap size, not memory

  // Run store
  logic [RUN_BITS-1:0] mem [MAX_RUNS];
  logic [RUN_BITS-1:0] rd_q;
  logic [AW-1:0]       rd_addr, rd_addr_q;
  logic [RUN_BITS-1:0] rd_val;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [RUN_BITS-1:0] mem_wd;

  // Command context
  logic [1:0]       func_r;
  logic [7:0]       x_r, y_r;
  logic             val_r;
  logic [POS_W-1:0] p_r;
  logic             bit_r;
  logic [1:0]       stat_r;

  // Walk
  logic [CW-1:0]       widx, cur;
  logic                wv;
  logic [VW-1:0]       acc;
  logic [RUN_BITS-1:0] prev_len, hlen, off;

  // Move and patch plan
  logic [CW-1:0]       mv_src, mv_dst, mv_n, mv_pdst;
  logic                mv_up, mv_pend;
  logic [CW-1:0]       pa [3];
  logic [RUN_BITS-1:0] pv [3];
  logic [2:0]          pe;
  logic [1:0]          pptr;

  logic [POS_W-1:0] p_c;
  logic [POS_W-1:0] prod;
  logic [VW-1:0]    prod_v, size_v;
  logic [VW-1:0]    sum;
  logic             hit;

  // Bitmap size, saturated to the run width
  assign prod   = POS_W'({8'd0, grid_width} * {8'd0, grid_height});
  assign prod_v = VW'(prod);
  assign size_v = (prod_v > RUN_MAX) ? RUN_MAX : prod_v;

  assign p_c = POS_W'({8'd0, cmd.y_pos} * {8'd0, grid_width}) + POS_W'(cmd.x_pos);

  assign rd_val = (head_fresh && rd_addr_q == '0) ? size_v[RUN_BITS-1:0] : rd_q;
  assign sum    = acc + VW'(rd_val);
  assign hit    = sum > VW'(p_r);

  assign busy = (state != S_IDLE);

  // Memory address and write selection
  always_comb begin
    rd_addr = widx[AW-1:0];
    mem_we  = 1'b0;
    mem_wa  = mv_pdst[AW-1:0];
    mem_wd  = rd_val;
    unique case (state)
      S_NRD:   rd_addr = AW'(cur + CNT_ONE);
      S_MOVE: begin
        rd_addr = mv_src[AW-1:0];
        mem_we  = mv_pend;
      end
      S_PATCH: begin
        mem_we = pe[pptr];
        mem_wa = pa[pptr][AW-1:0];
        mem_wd = pv[pptr];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q      <= mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      run_count   <= CNT_ONE;
      first_zero  <= 1'b1;
      head_fresh  <= 1'b1;
      done        <= 1'b0;
      mv_pend     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (mem_we && mem_wa == '0) begin
        head_fresh <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          // Register writes also clear the bitmap to one zero run
          if (cfg_we) begin
            if (cfg_idx == REG_GRID_WIDTH) begin
              grid_width <= cfg_data;
            end else begin
              grid_height <= cfg_data;
            end
            run_count  <= CNT_ONE;
            first_zero <= 1'b1;
            head_fresh <= 1'b1;
          end else if (start) begin
            func_r <= cmd.func;
            x_r    <= cmd.x_pos;
            y_r    <= cmd.y_pos;
            val_r  <= cmd.set_value;
            p_r    <= p_c;
            bit_r  <= 1'b0;
            stat_r <= STAT_OK;
            if (cmd.func == FUNC_CLEAR) begin
              run_count  <= CNT_ONE;
              first_zero <= 1'b1;
              head_fresh <= 1'b1;
              state      <= S_DONE;
            end else if (cmd.func == FUNC_READ || cmd.func == FUNC_WRITE) begin
              state <= S_CHK;
            end else begin
              state <= S_DONE;
            end
          end
        end

        S_CHK: begin
          widx <= '0;
          wv   <= 1'b0;
          acc  <= '0;
          if (x_r >= grid_width || y_r >= grid_height || VW'(p_r) >= size_v) begin
            stat_r <= STAT_OOB;
            state  <= S_DONE;
          end else begin
            state <= S_WALK;
          end
        end

        // One run per cycle: address widx goes out while run widx-1 is compared
        S_WALK: begin
          if (wv && hit) begin
            cur  <= widx - CNT_ONE;
            hlen <= rd_val;
            off  <= RUN_BITS'(VW'(p_r) - acc);
            if (func_r == FUNC_READ) begin
              bit_r <= ~first_zero ^ widx[0] ^ 1'b1;
              state <= S_DONE;
            end else if ((~first_zero ^ ~widx[0]) == val_r) begin
              state <= S_DONE;
            end else begin
              state <= S_NRD;
            end
          end else begin
            if (wv) begin
              acc      <= sum;
              prev_len <= rd_val;
            end
            widx <= widx + CNT_ONE;
            wv   <= 1'b1;
          end
        end

        S_NRD: state <= S_NCAP;

        // Plan the edit; rd_val holds the following run's length
        S_NCAP: begin
          mv_n  <= '0;
          mv_up <= 1'b1;
          pe    <= 3'b000;
          pptr  <= '0;
          state <= S_MOVE;
          if (hlen == RUN_BITS'(1)) begin
            if (run_count == CNT_ONE) begin
              first_zero <= ~first_zero;
            end else if (cur == '0) begin
              first_zero <= ~first_zero;
              mv_src     <= CNT_ONE;
              mv_dst     <= '0;
              mv_n       <= run_count - CNT_ONE;
              pa[0]      <= '0;
              pv[0]      <= rd_val + RUN_BITS'(1);
              pe         <= 3'b001;
              run_count  <= run_count - CNT_ONE;
            end else if (cur == run_count - CNT_ONE) begin
              pa[0]     <= cur - CNT_ONE;
              pv[0]     <= prev_len + RUN_BITS'(1);
              pe        <= 3'b001;
              run_count <= run_count - CNT_ONE;
            end else begin
              // Merge left neighbor, this bit and right neighbor
              pa[0]     <= cur - CNT_ONE;
              pv[0]     <= prev_len + RUN_BITS'(1) + rd_val;
              pe        <= 3'b001;
              mv_src    <= cur + CW'(2);
              mv_dst    <= cur;
              mv_n      <= run_count - cur - CW'(2);
              run_count <= run_count - CW'(2);
            end
          end else if (off == '0) begin
            if (cur == '0) begin
              if (run_count == CNT_MAX) begin
                stat_r <= STAT_FULL;
              end else begin
                first_zero <= ~first_zero;
                mv_up      <= 1'b0;
                mv_src     <= run_count - CNT_ONE;
                mv_dst     <= run_count;
                mv_n       <= run_count;
                pa[0]      <= '0;
                pv[0]      <= RUN_BITS'(1);
                pa[1]      <= CNT_ONE;
                pv[1]      <= hlen - RUN_BITS'(1);
                pe         <= 3'b011;
                run_count  <= run_count + CNT_ONE;
              end
            end else begin
              pa[0] <= cur - CNT_ONE;
              pv[0] <= prev_len + RUN_BITS'(1);
              pa[1] <= cur;
              pv[1] <= hlen - RUN_BITS'(1);
              pe    <= 3'b011;
            end
          end else if (off == hlen - RUN_BITS'(1)) begin
            if (cur != run_count - CNT_ONE) begin
              pa[0] <= cur;
              pv[0] <= hlen - RUN_BITS'(1);
              pa[1] <= cur + CNT_ONE;
              pv[1] <= rd_val + RUN_BITS'(1);
              pe    <= 3'b011;
            end else if (run_count == CNT_MAX) begin
              stat_r <= STAT_FULL;
            end else begin
              pa[0]     <= cur;
              pv[0]     <= hlen - RUN_BITS'(1);
              pa[1]     <= cur + CNT_ONE;
              pv[1]     <= RUN_BITS'(1);
              pe        <= 3'b011;
              run_count <= run_count + CNT_ONE;
            end
          end else begin
            // Split the run in three
            if (run_count >= CNT_MAX - CNT_ONE) begin
              stat_r <= STAT_FULL;
            end else begin
              mv_up     <= 1'b0;
              mv_src    <= run_count - CNT_ONE;
              mv_dst    <= run_count + CNT_ONE;
              mv_n      <= run_count - cur - CNT_ONE;
              pa[0]     <= cur;
              pv[0]     <= off;
              pa[1]     <= cur + CNT_ONE;
              pv[1]     <= RUN_BITS'(1);
              pa[2]     <= cur + CW'(2);
              pv[2]     <= hlen - off - RUN_BITS'(1);
              pe        <= 3'b111;
              run_count <= run_count + CW'(2);
            end
          end
        end

        // Read one entry, write the previous one: one move per cycle
        S_MOVE: begin
          if (mv_n != '0) begin
            mv_src  <= mv_up ? mv_src + CNT_ONE : mv_src - CNT_ONE;
            mv_dst  <= mv_up ? mv_dst + CNT_ONE : mv_dst - CNT_ONE;
            mv_pdst <= mv_dst;
            mv_n    <= mv_n - CNT_ONE;
            mv_pend <= 1'b1;
          end else begin
            mv_pend <= 1'b0;
            if (!mv_pend) begin
              state <= S_PATCH;
            end
          end
        end

        S_PATCH: begin
          pptr <= pptr + 2'd1;
          if (pptr == 2'd2) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          done             <= 1'b1;
          result.bit_value <= bit_r;
          result.status    <= stat_r;
          result.is_empty  <= (run_count == CNT_ONE) && first_zero;
          result.runs_used <= 9'(run_count);
          state            <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/run_length_bitmap_store_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_length_bitmap_store_core_tb
// Self-checking bench: a directed table, then random command traffic over
// several grid sizes; each result is checked against its table row or an in-bench run-list model.
// ----------------------------------------------------------------------------
module run_length_bitmap_store_core_tb;
  import rlbs_pkg::*;

  localparam int RUNS       = MAX_RUNS_DEF;
  localparam int SIZE_CAP   = 65535;
  localparam int DRAIN_WAIT = 600;
  localparam int WDOG_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  cmd_t       cmd = '0;
  logic       done;
  res_t       result;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_idx = REG_GRID_WIDTH;
  logic [7:0] cfg_data = 8'd0;

  run_length_bitmap_store_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Run-list model of the bitmap
  // --------------------------------------------------------------------------
  int unsigned run_len[RUNS+1];
  int unsigned run_cnt;
  bit          zero_first;
  int unsigned grid_w = 10, grid_h = 10;

  function automatic int unsigned grid_size();
    int unsigned t;
    t = grid_w * grid_h;
    return (t > SIZE_CAP) ? SIZE_CAP : t;
  endfunction

  function automatic void wipe_runs();
    for (int i = 0; i <= RUNS; i++) run_len[i] = 0;
    run_len[0] = grid_size();
    run_cnt = 1;
    zero_first = 1'b1;
  endfunction

  function automatic void drop_runs(int unsigned at, int unsigned n);
    for (int unsigned i = at; i + n < run_cnt; i++) run_len[i] = run_len[i+n];
    run_cnt -= n;
  endfunction

  function automatic void open_run(int unsigned at, int unsigned len);
    for (int unsigned i = run_cnt; i > at; i--) run_len[i] = run_len[i-1];
    run_len[at] = len;
    run_cnt += 1;
  endfunction

  function automatic logic run_bit(int unsigned i);
    return (zero_first ? 1'b0 : 1'b1) ^ i[0];
  endfunction

  // Edit the runs so the list stays canonical; return the status code.
  function automatic logic [1:0] store_bit(int unsigned p, logic v);
    int unsigned acc, len, off;
    acc = 0;
    for (int unsigned i = 0; i < run_cnt; i++) begin
      len = run_len[i];
      if (acc + len <= p) begin
        acc += len;
        continue;
      end
      if (run_bit(i) == v) return STAT_OK;
      off = p - acc;
      if (len == 1) begin
        if (run_cnt == 1) begin
          zero_first = !zero_first;
        end else if (i == 0) begin
          zero_first = !zero_first;
          drop_runs(0, 1);
          run_len[0] += 1;
        end else if (i == run_cnt - 1) begin
          drop_runs(i, 1);
          run_len[i-1] += 1;
        end else begin
          run_len[i-1] += 1 + run_len[i+1];
          drop_runs(i, 2);
        end
        return STAT_OK;
      end
      if (off == 0) begin
        if (i == 0) begin
          if (run_cnt + 1 > RUNS) return STAT_FULL;
          open_run(0, 1);
          run_len[1] -= 1;
          zero_first = !zero_first;
        end else begin
          run_len[i-1] += 1;
          run_len[i] -= 1;
        end
        return STAT_OK;
      end
      if (off == len - 1) begin
        if (i + 1 < run_cnt) begin
          run_len[i] -= 1;
          run_len[i+1] += 1;
        end else begin
          if (run_cnt + 1 > RUNS) return STAT_FULL;
          run_len[i] -= 1;
          open_run(i + 1, 1);
        end
        return STAT_OK;
      end
      if (run_cnt + 2 > RUNS) return STAT_FULL;
      run_len[i] = off;
      open_run(i + 1, len - off - 1);
      open_run(i + 1, 1);
      return STAT_OK;
    end
    return STAT_OK;
  endfunction

  function automatic logic fetch_bit(int unsigned p);
    int unsigned acc;
    acc = 0;
    for (int unsigned i = 0; i < run_cnt; i++) begin
      if (acc + run_len[i] > p) return run_bit(i);
      acc += run_len[i];
    end
    return 1'b0;
  endfunction

  function automatic res_t bitmap_step(cmd_t c);
    res_t        r;
    int unsigned p;
    r = '0;
    if (c.func == FUNC_CLEAR) begin
      wipe_runs();
    end else if (c.func == FUNC_READ || c.func == FUNC_WRITE) begin
      p = c.y_pos * grid_w + c.x_pos;
      if (c.x_pos >= grid_w || c.y_pos >= grid_h || p >= grid_size())
        r.status = STAT_OOB;
      else if (c.func == FUNC_READ)
        r.bit_value = fetch_bit(p);
      else
        r.status = store_bit(p, c.set_value);
    end
    r.is_empty  = (run_cnt == 1) && zero_first;
    r.runs_used = run_cnt[8:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted command, check each result strobe
  // --------------------------------------------------------------------------
  res_t expected_res[$];
  logic cur_typed = 1'b0;   // directed row carries its own expected result
  res_t cur_exp = '0;
  int   fail_cnt = 0, idle_cnt = 0;
  int   n_cmd = 0, n_res = 0, n_oob = 0, n_full = 0, n_cfg = 0;

  always @(posedge clk) begin
    res_t pr, ex;
    if (!rst) begin
      if (cfg_we) begin
        // A register write also wipes the bitmap to the new size.
        if (cfg_idx == REG_GRID_WIDTH) grid_w = 32'(cfg_data);
        else grid_h = 32'(cfg_data);
        wipe_runs();
        n_cfg++;
      end
      if (start && !busy) begin
        pr = bitmap_step(cmd);
        expected_res.push_back(cur_typed ? cur_exp : pr);
        n_cmd++;
      end
      if (done) begin
        n_res++;
        if (result.status == STAT_OOB) n_oob++;
        if (result.status == STAT_FULL) n_full++;
        if (expected_res.size() == 0) begin
          $error("result with no transaction outstanding: %p", result);
          fail_cnt++;
        end else begin
          ex = expected_res.pop_front();
          if (result.bit_value !== ex.bit_value) begin
            $error("bit_value exp %0d got %0d", ex.bit_value, result.bit_value);
            fail_cnt++;
          end
          if (result.status !== ex.status) begin
            $error("status exp %0d got %0d", ex.status, result.status);
            fail_cnt++;
          end
          if (result.is_empty !== ex.is_empty) begin
            $error("is_empty exp %0d got %0d", ex.is_empty, result.is_empty);
            fail_cnt++;
          end
          if (result.runs_used !== ex.runs_used) begin
            $error("runs_used exp %0d got %0d", ex.runs_used, result.runs_used);
            fail_cnt++;
          end
        end
      end
      // Watchdog: any transaction, result or register write resets it.
      if ((start && !busy) || done || cfg_we) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_res.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  int idle_pct = 0;

  // Hold start low for a random gap, then present one command until taken.
  task automatic send_cmd(cmd_t c, logic typed, res_t ex);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk) start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    cmd = c;
    cur_typed = typed;
    cur_exp = ex;
    do @(posedge clk); while (busy);
  endtask

  // Wait for every outstanding result, then let the block settle.
  task automatic drain();
    @(negedge clk) start = 1'b0;
    while (expected_res.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk) cfg_we = 1'b0;
  endtask

  task automatic set_grid(logic [7:0] w, logic [7:0] h);
    drain();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
  endtask

  // General mix: mostly in-range reads and writes, some wild coordinates.
  function automatic cmd_t mixed_cmd();
    cmd_t c;
    int   k;
    k = $urandom_range(99);
    c.func = (k < 3) ? FUNC_CLEAR : (k < 6) ? FUNC_NOP : (k < 40) ? FUNC_READ : FUNC_WRITE;
    if ($urandom_range(99) < 85 && grid_w > 0 && grid_h > 0) begin
      c.x_pos = 8'($urandom_range(grid_w - 1));
      c.y_pos = 8'($urandom_range(grid_h - 1));
    end else begin
      c.x_pos = 8'($urandom_range(255));
      c.y_pos = 8'($urandom_range(255));
    end
    c.set_value = 1'($urandom_range(1));
    return c;
  endfunction

  // Run-store stress: isolated ones on a wide grid pile up runs until full.
  function automatic cmd_t packing_cmd();
    cmd_t c;
    int   k;
    k = $urandom_range(99);
    c.func = (k < 15) ? FUNC_READ : FUNC_WRITE;
    c.x_pos = 8'(2 * $urandom_range(grid_w > 1 ? (grid_w - 1) / 2 : 0));
    c.y_pos = 8'($urandom_range(grid_h > 3 ? 2 : grid_h - 1));
    c.set_value = (k < 90) ? 1'b1 : 1'b0;
    return c;
  endfunction

  typedef struct {
    cmd_t c;
    logic typed;
    res_t ex;
  } step_row_t;

  localparam res_t EMPTY_OK = '{1'b0, STAT_OK, 1'b1, 9'd1};
  localparam res_t EMPTY_OOB = '{1'b0, STAT_OOB, 1'b1, 9'd1};

  // Directed table on the reset 10x10 grid.
  step_row_t steps[] = '{
    '{'{FUNC_READ,  8'd0,   8'd0,   1'b0}, 1'b1, EMPTY_OK},
    '{'{FUNC_READ,  8'd10,  8'd0,   1'b0}, 1'b1, EMPTY_OOB},
    '{'{FUNC_READ,  8'd0,   8'd10,  1'b1}, 1'b1, EMPTY_OOB},
    '{'{FUNC_READ,  8'd255, 8'd255, 1'b1}, 1'b1, EMPTY_OOB},
    '{'{FUNC_WRITE, 8'd0,   8'd0,   1'b0}, 1'b1, EMPTY_OK},
    '{'{FUNC_WRITE, 8'd0,   8'd0,   1'b1}, 1'b1, '{1'b0, STAT_OK, 1'b0, 9'd2}},
    '{'{FUNC_WRITE, 8'd0,   8'd0,   1'b1}, 1'b1, '{1'b0, STAT_OK, 1'b0, 9'd2}},
    '{'{FUNC_WRITE, 8'd9,   8'd9,   1'b1}, 1'b1, '{1'b0, STAT_OK, 1'b0, 9'd3}},
    '{'{FUNC_READ,  8'd9,   8'd9,   1'b0}, 1'b1, '{1'b1, STAT_OK, 1'b0, 9'd3}},
    '{'{FUNC_WRITE, 8'd5,   8'd0,   1'b1}, 1'b0, '0},
    '{'{FUNC_WRITE, 8'd4,   8'd0,   1'b1}, 1'b0, '0},
    '{'{FUNC_WRITE, 8'd8,   8'd9,   1'b1}, 1'b0, '0},
    '{'{FUNC_WRITE, 8'd6,   8'd0,   1'b1}, 1'b0, '0},
    '{'{FUNC_WRITE, 8'd5,   8'd0,   1'b0}, 1'b0, '0},
    '{'{FUNC_WRITE, 8'd0,   8'd0,   1'b0}, 1'b0, '0},
    '{'{FUNC_WRITE, 8'd9,   8'd9,   1'b0}, 1'b0, '0},
    '{'{FUNC_READ,  8'd4,   8'd0,   1'b0}, 1'b0, '0},
    '{'{FUNC_WRITE, 8'd255, 8'd0,   1'b1}, 1'b0, '0},
    '{'{FUNC_NOP,   8'd255, 8'd255, 1'b1}, 1'b0, '0},
    '{'{FUNC_WRITE, 8'd0,   8'd9,   1'b1}, 1'b0, '0},
    '{'{FUNC_CLEAR, 8'd255, 8'd255, 1'b1}, 1'b1, EMPTY_OK},
    '{'{FUNC_READ,  8'd9,   8'd9,   1'b0}, 1'b1, EMPTY_OK}
  };

  task automatic random_phase(int n, int pct, bit packing);
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      send_cmd(packing ? packing_cmd() : mixed_cmd(), 1'b0, '0);
      // In phases with a 17 percent idle rate, pause once mid-phase until every outstanding result is back.
      if (i == n / 2 && pct == 17) begin
        @(negedge clk) start = 1'b0;
        while (expected_res.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    wipe_runs();
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed rows back to back, then random traffic on the reset grid.
    idle_pct = 0;
    foreach (steps[i]) send_cmd(steps[i].c, steps[i].typed, steps[i].ex);
    random_phase(150, 0, 1'b0);

    set_grid(8'd3, 8'd2);
    random_phase(100, 63, 1'b0);

    // Largest grid: fill the run store until writes are refused.
    set_grid(8'd255, 8'd255);
    random_phase(220, 17, 1'b1);

    set_grid(8'd1, 8'd1);
    random_phase(60, 17, 1'b0);

    // Zero-width grid: every coordinate is out of range.
    set_grid(8'd0, 8'd7);
    random_phase(15, 0, 1'b0);

    set_grid(8'd255, 8'd1);
    random_phase(140, 17, 1'b1);

    set_grid(8'd16, 8'd16);
    random_phase(80, 63, 1'b0);

    drain();
    fail_cnt += expected_res.size();
    $display("covered %0d commands, %0d results, %0d register writes", n_cmd, n_res, n_cfg);
    $display("out-of-range results %0d, store-full refusals %0d", n_oob, n_full);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rlbs_pkg.sv
rtl/run_length_bitmap_store_core.sv
tb/run_length_bitmap_store_core_tb.sv
